@@ hdl/nps_pkg.sv @@
package nps_pkg;

  // Field widths fixed by the job and result formats.
  localparam int TIME_W    = 16;
  localparam int URG_W     = 3;
  localparam int JOB_IDX_W = 5;

  // Default depth of the job table.
  localparam int MAX_JOBS_DEF = 32;

  // Time constants, unsigned fixed point with four fraction bits.
  localparam logic [TIME_W-1:0] TIME_MAX        = {TIME_W{1'b1}};
  localparam logic [TIME_W-1:0] QUANTUM         = TIME_W'(16);
  localparam logic [TIME_W-1:0] START_LIMIT_RST = TIME_W'(1584);

  // Urgency level that marks "nothing picked"; jobs at or above it never run.
  localparam logic [URG_W-1:0] NO_PICK = URG_W'(5);

  // One job request as it enters the block.
  typedef struct packed {
    logic [TIME_W-1:0] arrival;
    logic [TIME_W-1:0] service;
    logic [URG_W-1:0]  urgency;
    logic              last_job;
  } in_job_t;

  // One result as it leaves the block.
  typedef struct packed {
    logic [JOB_IDX_W-1:0] job_index;
    logic [TIME_W-1:0]    start_at;
    logic [TIME_W-1:0]    finish_at;
    logic [TIME_W-1:0]    response;
    logic [TIME_W-1:0]    waiting;
    logic [TIME_W-1:0]    turnaround;
    logic                 none_ran;
    logic                 last_result;
  } out_res_t;

  // One entry of the job table.
  typedef struct packed {
    logic [TIME_W-1:0] arrival;
    logic [TIME_W-1:0] service;
    logic [URG_W-1:0]  urgency;
  } job_ent_t;

  // Controller states.
  typedef enum logic [2:0] {
    S_LOAD,
    S_CHECK,
    S_SCAN,
    S_DRAIN,
    S_DECIDE,
    S_TURN,
    S_WAIT,
    S_END
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic sched_init;
    logic scan_init;
    logic scan_step;
    logic run;
    logic idle_step;
    logic turn;
    logic push;
    logic finish;
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic more_jobs;
    logic scan_last;
    logic have_pick;
    logic now_over;
    logic now_max;
    logic step_over;
    logic future;
  } dp_stat_t;

  // Saturating add of two times.
  function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                input logic [TIME_W-1:0] b);
    logic [TIME_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TIME_W] ? TIME_MAX : s[TIME_W-1:0];
  endfunction

endpackage

@@ hdl/nps_ctrl.sv @@
module nps_ctrl import nps_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  logic     last_job,
  input  dp_stat_t stat,
  output ctl_cmd_t cmd,
  output logic     busy
);

  state_t state_r;
  state_t state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_LOAD: begin
        if (start) begin
          cmd.load = 1'b1;
          if (last_job) begin
            cmd.sched_init = 1'b1;
            state_nxt      = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        if (stat.more_jobs) begin
          cmd.scan_init = 1'b1;
          state_nxt     = S_SCAN;
        end else begin
          state_nxt = S_END;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        priority if (stat.have_pick) begin
          if (stat.now_over) begin
            state_nxt = S_END;
          end else begin
            cmd.run   = 1'b1;
            state_nxt = S_TURN;
          end
        end else if (stat.now_max || stat.step_over || !stat.future) begin
          state_nxt = S_END;
        end else begin
          cmd.idle_step = 1'b1;
          state_nxt     = S_CHECK;
        end
      end
      S_TURN: begin
        cmd.turn  = 1'b1;
        state_nxt = S_WAIT;
      end
      S_WAIT: begin
        cmd.push  = 1'b1;
        state_nxt = S_CHECK;
      end
      S_END: begin
        cmd.finish = 1'b1;
        state_nxt  = S_LOAD;
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  // Requests are taken only while the table is loading.
  assign busy = (state_r != S_LOAD);

endmodule

@@ hdl/nps_dp.sv @@
module nps_dp import nps_pkg::*; #(
  parameter int MAX_JOBS = MAX_JOBS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  ctl_cmd_t          cmd,
  output dp_stat_t          stat,
  input  in_job_t           in_job,
  input  logic              cfg_we,
  input  logic [TIME_W-1:0] cfg_wdata,
  output logic              out_strobe,
  output out_res_t          out_res
);

  localparam int CNT_W = $clog2(MAX_JOBS + 1);
  localparam int IDX_W = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;

  // Job table memory, one read port and one write port.
  job_ent_t job_mem [MAX_JOBS];

  logic [TIME_W-1:0]   limit_r;
  logic [MAX_JOBS-1:0] done_r;
  logic [CNT_W-1:0]    count_r;
  logic [CNT_W-1:0]    finished_r;
  logic [TIME_W-1:0]   now_r;
  logic [TIME_W-1:0]   now_step_r;
  logic [IDX_W-1:0]    scan_idx_r;
  logic                rd_vld_r;
  logic [IDX_W-1:0]    rd_idx_r;
  job_ent_t            rd_r;
  logic [URG_W-1:0]    best_urg_r;
  logic [TIME_W-1:0]   best_arr_r;
  logic [TIME_W-1:0]   best_svc_r;
  logic [IDX_W-1:0]    best_idx_r;
  logic                future_r;
  logic [TIME_W-1:0]   start_r;
  logic [TIME_W-1:0]   fin_r;
  logic [TIME_W-1:0]   resp_r;
  logic [TIME_W-1:0]   turn_r;
  out_res_t            pend_r;
  logic                pend_vld_r;
  logic                out_strobe_r;
  out_res_t            out_res_r;

  logic                room;
  logic                live;
  logic                elig;
  logic                better;
  logic                fut_hit;
  logic [TIME_W-1:0]   fin_sum;
  logic [TIME_W-1:0]   wait_val;
  job_ent_t            wr_ent;
  out_res_t            new_res;
  out_res_t            none_res;

  // A job is stored only while the table has room.
  assign room = (count_r < CNT_W'(MAX_JOBS));

  assign wr_ent.arrival = in_job.arrival;
  assign wr_ent.service = in_job.service;
  assign wr_ent.urgency = in_job.urgency;

  // Memory write and registered read.
  always_ff @(posedge clk) begin
    if (cmd.load && room) begin
      job_mem[count_r[IDX_W-1:0]] <= wr_ent;
    end
    rd_r     <= job_mem[scan_idx_r];
    rd_idx_r <= scan_idx_r;
  end

  // Evaluation of the entry that came out of the memory.
  assign live    = rd_vld_r && !done_r[rd_idx_r];
  assign elig    = live && (rd_r.arrival <= now_r);
  assign better  = elig && ((rd_r.urgency < best_urg_r) ||
                            ((best_urg_r < NO_PICK) && (rd_r.urgency == best_urg_r) &&
                             (rd_r.arrival < best_arr_r)));
  assign fut_hit = live && (rd_r.arrival >= now_step_r);

  // Finish time of the picked job and its waiting time.
  assign fin_sum  = sat_add(now_r, best_svc_r);
  assign wait_val = (turn_r > best_svc_r) ? (turn_r - best_svc_r) : '0;

  always_comb begin
    new_res             = '0;
    new_res.job_index   = JOB_IDX_W'(best_idx_r);
    new_res.start_at    = start_r;
    new_res.finish_at   = fin_r;
    new_res.response    = resp_r;
    new_res.waiting     = wait_val;
    new_res.turnaround  = turn_r;
    none_res             = '0;
    none_res.none_ran    = 1'b1;
    none_res.last_result = 1'b1;
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r      <= START_LIMIT_RST;
      done_r       <= '0;
      count_r      <= '0;
      finished_r   <= '0;
      now_r        <= '0;
      scan_idx_r   <= '0;
      rd_vld_r     <= 1'b0;
      best_urg_r   <= NO_PICK;
      future_r     <= 1'b0;
      pend_vld_r   <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= 1'b0;
      rd_vld_r     <= cmd.scan_step;
      if (cfg_we) begin
        limit_r <= cfg_wdata;
      end
      // Loading a job.
      if (cmd.load && room) begin
        done_r[count_r[IDX_W-1:0]] <= 1'b0;
        count_r                    <= count_r + CNT_W'(1);
      end
      if (cmd.sched_init) begin
        now_r      <= '0;
        finished_r <= '0;
        pend_vld_r <= 1'b0;
      end
      // Table scan.
      priority if (cmd.scan_init) begin
        scan_idx_r <= '0;
        best_urg_r <= NO_PICK;
        future_r   <= 1'b0;
      end else begin
        if (better) begin
          best_urg_r <= rd_r.urgency;
        end
        if (fut_hit) begin
          future_r <= 1'b1;
        end
        if (cmd.scan_step) begin
          scan_idx_r <= scan_idx_r + IDX_W'(1);
        end
      end
      // Running the picked job or letting a quantum pass.
      if (cmd.run) begin
        now_r                  <= fin_sum;
        done_r[best_idx_r]     <= 1'b1;
        finished_r             <= finished_r + CNT_W'(1);
      end
      if (cmd.idle_step) begin
        now_r <= now_step_r;
      end
      // Results go out one behind, so that the final one can be marked.
      if (cmd.push) begin
        pend_vld_r <= 1'b1;
        if (pend_vld_r) begin
          out_strobe_r <= 1'b1;
        end
      end
      if (cmd.finish) begin
        out_strobe_r <= 1'b1;
        pend_vld_r   <= 1'b0;
        count_r      <= '0;
        done_r       <= '0;
        now_r        <= '0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.scan_init) begin
      now_step_r <= sat_add(now_r, QUANTUM);
    end
    if (!cmd.scan_init && better) begin
      best_arr_r <= rd_r.arrival;
      best_svc_r <= rd_r.service;
      best_idx_r <= rd_idx_r;
    end
    if (cmd.run) begin
      start_r <= now_r;
      fin_r   <= fin_sum;
      resp_r  <= now_r - best_arr_r;
    end
    if (cmd.turn) begin
      turn_r <= fin_r - best_arr_r;
    end
    if (cmd.push) begin
      pend_r <= new_res;
      if (pend_vld_r) begin
        out_res_r <= pend_r;
      end
    end
    if (cmd.finish) begin
      if (pend_vld_r) begin
        out_res_r             <= pend_r;
        out_res_r.last_result <= 1'b1;
      end else begin
        out_res_r <= none_res;
      end
    end
  end

  // Status to the controller.
  assign stat.more_jobs = (finished_r < count_r);
  assign stat.scan_last = (CNT_W'(scan_idx_r) == (count_r - CNT_W'(1)));
  assign stat.have_pick = (best_urg_r < NO_PICK);
  assign stat.now_over  = (now_r > limit_r);
  assign stat.now_max   = (now_r == TIME_MAX);
  assign stat.step_over = (now_step_r > limit_r);
  assign stat.future    = future_r;

  assign out_strobe = out_strobe_r;
  assign out_res    = out_res_r;

endmodule

@@ hdl/nonpreemptive_priority_scheduler.sv @@
// Channel   Ports                         Handshake
// input     start, busy, in_job           taken when start is high and busy low
// result    out_strobe, out_res           valid for the one cycle that out_strobe is high
// config    cfg_we, cfg_wdata             start_limit written when cfg_we is high
//
// Loading takes one job per cycle; busy stays low until the job marked last.
// Each scheduling decision scans the job table through the read port of the job
// memory in check, scan, drain and decide, then turn and wait when a job runs.
// Closing the schedule registers the final result, shown once busy is low again.
// Synchronous active-low reset empties the table and sets start_limit to 99.0.
// Results cannot be stalled; each is shown for exactly one cycle.
module nonpreemptive_priority_scheduler import nps_pkg::*; #(
  parameter int MAX_JOBS = MAX_JOBS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  in_job_t           in_job,
  output logic              out_strobe,
  output out_res_t          out_res,
  input  logic              cfg_we,
  input  logic [TIME_W-1:0] cfg_wdata
);

  ctl_cmd_t cmd;
  dp_stat_t stat;

  // Sequencer for loading and scheduling.
  nps_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .last_job (in_job.last_job),
    .stat     (stat),
    .cmd      (cmd),
    .busy     (busy)
  );

  // Job table, scan and timing arithmetic.
  nps_dp #(
    .MAX_JOBS (MAX_JOBS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_job     (in_job),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .out_strobe (out_strobe),
    .out_res    (out_res)
  );

  // The final result of a run appears once the table is open again.
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_res.last_result |-> !busy)
    else $error("final result while still scheduling");

  // Any earlier result appears while scheduling goes on.
  a_mid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_res.last_result |-> busy)
    else $error("non-final result after the run closed");

  // A job never finishes before it starts.
  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_res.none_ran |-> out_res.finish_at >= out_res.start_at)
    else $error("finish time before start time");

  // A job that is not the last keeps the block loading and silent.
  a_load: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && !in_job.last_job |=> !busy && !out_strobe)
    else $error("block left loading on an ordinary job");

  // The job marked last starts scheduling.
  a_kick: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_job.last_job |=> busy)
    else $error("scheduling did not start");

endmodule
